// ===== design/hpb_pkg.sv =====
`default_nettype none
package hpb_pkg;

  localparam int TEMP_WIDTH_DEF     = 10;
  localparam int INTEGRAL_LIMIT_DEF = 100;
  localparam int DUTY_MAX_DEF       = 10000;

  localparam int GAIN_WIDTH  = 16;
  localparam int INTEG_WIDTH = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_KP     = 3'd1,
    REG_KI     = 3'd2,
    REG_KD     = 3'd3,
    REG_ENABLE = 3'd4
  } hpb_reg_e;

  typedef struct packed {
    logic full;
    logic empty;
  } hpb_qstat_t;

endpackage
`default_nettype wire

// ===== design/hpb_front.sv =====
`default_nettype none
module hpb_front #(
  parameter int TEMP_WIDTH = 10
) (
  input  wire logic                  s_valid_i,
  input  wire logic [TEMP_WIDTH-1:0] meas_i,
  input  wire logic [TEMP_WIDTH-1:0] target_i,
  input  wire logic                  q_full_i,
  output logic                       s_ready_o,
  output logic                       push_o,
  output logic [TEMP_WIDTH+1:0]      entry_o
);

  localparam int EW = TEMP_WIDTH + 1;
  localparam int MW = TEMP_WIDTH + 4;

  logic [MW-1:0] meas_x10;
  logic [MW-1:0] target_x9;
  logic          boost;
  logic [EW-1:0] err;

  always_comb begin
    meas_x10  = (MW'(meas_i) << 3) + (MW'(meas_i) << 1);
    target_x9 = (MW'(target_i) << 3) + MW'(target_i);
    // boost below 90 percent of target, exact
    boost     = meas_x10 < target_x9;
    err       = {1'b0, target_i} - {1'b0, meas_i};
  end

  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;
  assign entry_o   = {boost, err};

endmodule
`default_nettype wire

// ===== design/hpb_queue.sv =====
`default_nettype none
module hpb_queue
  import hpb_pkg::*;
#(
  parameter int WIDTH = 12,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output hpb_qstat_t            stat_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  always_comb begin
    do_push  = push_i && (cnt_q != FullCnt);
    do_pop   = pop_i && (cnt_q != '0);
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.full  = cnt_q == FullCnt;
  assign stat_o.empty = cnt_q == '0;

endmodule
`default_nettype wire

// ===== design/hpb_back.sv =====
`default_nettype none
module hpb_back
  import hpb_pkg::*;
#(
  parameter int TEMP_WIDTH     = TEMP_WIDTH_DEF,
  parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
  parameter int DUTY_MAX       = DUTY_MAX_DEF,
  localparam int DW            = $clog2(DUTY_MAX + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_empty_i,
  input  wire logic [TEMP_WIDTH+1:0] q_entry_i,
  output logic                       pop_o,
  input  wire logic [GAIN_WIDTH-1:0] kp_i,
  input  wire logic [GAIN_WIDTH-1:0] ki_i,
  input  wire logic [GAIN_WIDTH-1:0] kd_i,
  input  wire logic                  enable_i,
  output logic                       m_valid_o,
  input  wire logic                  m_ready_i,
  output logic [DW-1:0]              duty_o,
  output logic                       boosting_o
);

  localparam int EW  = TEMP_WIDTH + 1;
  localparam int IW  = INTEG_WIDTH;
  localparam int SW  = EW + 1;
  localparam int DFW = EW + 1;
  localparam int GW  = GAIN_WIDTH + 1;
  localparam int PPW = GW + EW;
  localparam int PIW = GW + IW;
  localparam int PDW = GW + DFW;
  localparam int NW  = PDW + 6;
  localparam int QW  = NW + 3;
  localparam logic signed [SW-1:0] LimPos = SW'(INTEGRAL_LIMIT);
  localparam logic signed [SW-1:0] LimNeg = -LimPos;
  localparam logic [QW-1:0] DutyMaxQ = QW'(DUTY_MAX);
  localparam logic [DW-1:0] DutyMaxW = DW'(DUTY_MAX);

  logic advance;

  // controller state
  logic signed [IW-1:0]  integ_q;
  logic signed [EW-1:0]  prev_e_q;

  // stage A: state update
  logic                  a_valid_q, a_boost_q;
  logic signed [EW-1:0]  a_e_q;
  logic signed [IW-1:0]  a_integ_q;
  logic signed [DFW-1:0] a_diff_q;

  // stage B: products
  logic                  b_valid_q, b_boost_q;
  logic signed [PPW-1:0] b_pkp_q;
  logic signed [PIW-1:0] b_pki_q;
  logic signed [PDW-1:0] b_pkd_q;

  // stage C: weighted sum
  logic                  c_valid_q, c_boost_q;
  logic signed [NW-1:0]  c_n_q;

  // output register
  logic                  m_valid_q, m_boost_q;
  logic [DW-1:0]         m_duty_q;

  logic                  h_boost;
  logic signed [EW-1:0]  h_e;
  logic signed [SW-1:0]  sum_raw;
  logic signed [IW-1:0]  sum_clamp;
  logic signed [DFW-1:0] diff;

  logic signed [GW-1:0]  kp_s, ki_s, kd_s;
  logic signed [NW-1:0]  n_kp, n_ki, n_kd, n_sum;
  logic [QW-1:0]         n5, quot;
  logic [DW-1:0]         duty_calc;

  assign advance = !m_valid_q || m_ready_i;
  assign pop_o   = advance && !q_empty_i;

  always_comb begin
    h_boost = q_entry_i[EW];
    h_e     = q_entry_i[EW-1:0];
    sum_raw = {{(SW-IW){integ_q[IW-1]}}, integ_q} + {h_e[EW-1], h_e};
    if (sum_raw > LimPos) begin
      sum_clamp = LimPos[IW-1:0];
    end else if (sum_raw < LimNeg) begin
      sum_clamp = LimNeg[IW-1:0];
    end else begin
      sum_clamp = sum_raw[IW-1:0];
    end
    diff = {prev_e_q[EW-1], prev_e_q} - {h_e[EW-1], h_e};
  end

  always_comb begin
    kp_s = {1'b0, kp_i};
    ki_s = {1'b0, ki_i};
    kd_s = {1'b0, kd_i};
  end

  always_comb begin
    n_kp  = {{(NW-PPW){b_pkp_q[PPW-1]}}, b_pkp_q};
    n_ki  = {{(NW-PIW){b_pki_q[PIW-1]}}, b_pki_q};
    n_kd  = {{(NW-PDW){b_pkd_q[PDW-1]}}, b_pkd_q};
    n_sum = (n_kp <<< 3) + (n_kp <<< 1) + n_ki + n_kd;
  end

  always_comb begin
    // duty = floor(5*N/128) for positive N
    n5   = {3'b000, c_n_q} + {1'b0, c_n_q, 2'b00};
    quot = n5 >> 7;
    if (c_boost_q) begin
      duty_calc = DutyMaxW;
    end else if (c_n_q[NW-1] || (c_n_q == '0)) begin
      duty_calc = '0;
    end else if (quot > DutyMaxQ) begin
      duty_calc = DutyMaxW;
    end else begin
      duty_calc = quot[DW-1:0];
    end
    if (!enable_i) begin
      duty_calc = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q   <= '0;
      prev_e_q  <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (advance) begin
      a_valid_q <= !q_empty_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      m_valid_q <= c_valid_q;
      // boost words leave the state untouched
      if (!q_empty_i && !h_boost) begin
        integ_q  <= sum_clamp;
        prev_e_q <= h_e;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_boost_q <= h_boost;
      a_e_q     <= h_e;
      a_integ_q <= sum_clamp;
      a_diff_q  <= diff;
      b_boost_q <= a_boost_q;
      b_pkp_q   <= kp_s * a_e_q;
      b_pki_q   <= ki_s * a_integ_q;
      b_pkd_q   <= kd_s * a_diff_q;
      c_boost_q <= b_boost_q;
      c_n_q     <= n_sum;
      m_boost_q <= c_boost_q;
      m_duty_q  <= duty_calc;
    end
  end

  assign m_valid_o  = m_valid_q;
  assign duty_o     = m_duty_q;
  assign boosting_o = m_boost_q;

endmodule
`default_nettype wire

// ===== design/heater_pid_with_boost.sv =====
// Heater PID controller with integral clamp and boost.
// An accepted word is written to the queue, then passes the state update, gain
// product, weighted sum and saturation registers before its output is valid.
// Throughput: one word per cycle while the output is not stalled; for non-boost
// words, integral and previous error update in the cycle the word leaves the
// queue, and an output stall freezes the back pipeline while the four-word
// queue absorbs input.
// Reset (rst_ni low, asynchronous): configuration registers, integral and
// previous error clear to zero; the queue empties and no output word is pending.
`default_nettype none
module heater_pid_with_boost
  import hpb_pkg::*;
#(
  parameter int TEMP_WIDTH     = TEMP_WIDTH_DEF,
  parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
  parameter int DUTY_MAX       = DUTY_MAX_DEF,
  localparam int DW            = $clog2(DUTY_MAX + 1),
  localparam int IN_TW         = ((TEMP_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW        = ((DW + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [IN_TW-1:0]  s_axis_tdata_i,   // [TEMP_WIDTH-1:0] measured_temp
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [OUT_TW-1:0]      m_axis_tdata_o,   // [DW-1:0] duty
  output logic                   m_axis_tuser_o    // [0] boosting
);

  localparam int EntW = TEMP_WIDTH + 2;

  logic [TEMP_WIDTH-1:0] target_q;
  logic [GAIN_WIDTH-1:0] kp_q, ki_q, kd_q;
  logic                  enable_q;

  logic       cfg_wr;
  hpb_reg_e   cfg_idx;
  hpb_qstat_t q_stat;
  logic       push, pop;
  logic [EntW-1:0] push_entry, head_entry;
  logic [DW-1:0]   duty;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = hpb_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      enable_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TARGET: target_q <= pwdata[TEMP_WIDTH-1:0];
        REG_KP:     kp_q     <= pwdata[GAIN_WIDTH-1:0];
        REG_KI:     ki_q     <= pwdata[GAIN_WIDTH-1:0];
        REG_KD:     kd_q     <= pwdata[GAIN_WIDTH-1:0];
        REG_ENABLE: enable_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TARGET: prdata = CFG_DW'(target_q);
      REG_KP:     prdata = CFG_DW'(kp_q);
      REG_KI:     prdata = CFG_DW'(ki_q);
      REG_KD:     prdata = CFG_DW'(kd_q);
      REG_ENABLE: prdata = CFG_DW'(enable_q);
      default:    prdata = '0;
    endcase
  end

  hpb_front #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_front (
    .s_valid_i (s_axis_tvalid_i),
    .meas_i    (s_axis_tdata_i[TEMP_WIDTH-1:0]),
    .target_i  (target_q),
    .q_full_i  (q_stat.full),
    .s_ready_o (s_axis_tready_o),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  hpb_queue #(
    .WIDTH (EntW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .stat_o  (q_stat)
  );

  hpb_back #(
    .TEMP_WIDTH     (TEMP_WIDTH),
    .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
    .DUTY_MAX       (DUTY_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_stat.empty),
    .q_entry_i  (head_entry),
    .pop_o      (pop),
    .kp_i       (kp_q),
    .ki_i       (ki_q),
    .kd_i       (kd_q),
    .enable_i   (enable_q),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .duty_o     (duty),
    .boosting_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = OUT_TW'(duty);

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (duty <= DW'(DUTY_MAX)))
    else $error("duty above maximum");

  a_boost_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (duty == DW'(DUTY_MAX) || duty == '0))
    else $error("boost word without full or zero duty");

  a_queue_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && q_stat.empty) |=> !q_stat.empty)
    else $error("accepted word lost in queue");

  a_queue_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

endmodule
`default_nettype wire
